// ----- rtl/core/asw_pkg.sv -----
`timescale 1ns / 1ps
// asw_pkg: widths, register indexes, reset values and the dimension clamp
// for the axis squash wrap address unit. depends on nothing.

package asw_pkg;

   localparam int COORD_W       = 12;
   localparam int CFG_DIM_W     = 13;
   localparam int SCALE_W       = 28;
   localparam int ADDR_W        = 24;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = SCALE_W;
   localparam int MAX_DIM       = 4096;
   localparam int FRAC_BITS_DEF = 16;
   localparam int WRAP_STEP     = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_HORIZONTAL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd3;

   localparam logic                 RST_HORIZONTAL   = 1'b1;
   localparam logic [SCALE_W-1:0]   RST_SCALE        = 28'd65536;
   localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH  = 13'd640;
   localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT = 13'd480;

   // zero becomes one, anything above the largest frame is clamped
   function automatic logic [CFG_DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
      if (v == '0) begin
         return CFG_DIM_W'(1);
      end
      if (v > MAX_DIM) begin
         return CFG_DIM_W'(MAX_DIM);
      end
      return v;
   endfunction

endpackage

// ----- rtl/core/asw_wrap.sv -----
`timescale 1ns / 1ps
// asw_wrap: pipelined floor modulo of a two's complement value by a frame
// dimension, STEP quotient bits per stage. depends on asw_pkg.

module asw_wrap #(
   parameter int VAL_W = 26,
   parameter int DIM_W = asw_pkg::CFG_DIM_W,
   parameter int STEP  = asw_pkg::WRAP_STEP
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [VAL_W-1:0] in_value,
   input  logic [DIM_W-1:0] dim,
   output logic             out_valid,
   output logic [DIM_W-1:0] out_rem
);

   localparam int N     = (VAL_W + STEP - 1) / STEP;
   localparam int PAD_W = N * STEP;

   logic [N:0]       vld_ff;
   logic [N:0]       neg_ff;
   logic [PAD_W-1:0] mag_ff [N:0];
   logic [DIM_W-1:0] rem_ff [N:0];
   logic             out_valid_ff;
   logic [DIM_W-1:0] out_rem_ff;
   logic [DIM_W-1:0] out_rem_in;
   logic [VAL_W-1:0] abs_val;

   // magnitude and sign
   assign abs_val = in_value[VAL_W-1] ? (~in_value + 1'b1) : in_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff[0] <= in_value[VAL_W-1];
      mag_ff[0] <= PAD_W'(abs_val);
      rem_ff[0] <= '0;
   end

   for (genvar k = 1; k <= N; k++) begin : g_stage
      logic [DIM_W-1:0] rem_in;
      logic [PAD_W-1:0] mag_in;
      logic [DIM_W:0]   cand;

      always_comb begin
         rem_in = rem_ff[k-1];
         mag_in = mag_ff[k-1];
         cand   = '0;
         for (int j = 0; j < STEP; j++) begin
            cand   = {rem_in, mag_in[PAD_W-1]};
            mag_in = {mag_in[PAD_W-2:0], 1'b0};
            if (cand >= {1'b0, dim}) begin
               rem_in = DIM_W'(cand - {1'b0, dim});
            end else begin
               rem_in = cand[DIM_W-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         neg_ff[k] <= neg_ff[k-1];
         mag_ff[k] <= mag_in;
         rem_ff[k] <= rem_in;
      end
   end

   // negative dividend with nonzero remainder folds back into range
   assign out_rem_in = (neg_ff[N] && (rem_ff[N] != '0)) ? (dim - rem_ff[N]) : rem_ff[N];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= vld_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      out_rem_ff <= out_rem_in;
   end

   assign out_valid = out_valid_ff;
   assign out_rem   = out_rem_ff;

   a_fwd_latency: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##(N+2) out_valid)
      else $error("wrap result missing");

   a_bwd_latency: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(in_valid, N+2))
      else $error("wrap result without input");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !out_valid)
      else $error("wrap result after reset");

endmodule

// ----- rtl/core/axis_squash_wrap_address_unit.sv -----
`timescale 1ns / 1ps
// axis_squash_wrap_address_unit: centred axis squash source address, top level.
// depends on asw_pkg and asw_wrap.
//
//   channel   ports                                  handshake
//   request   req_out_x, req_out_y                   start high, busy low
//   response  rsp_src_x, rsp_src_y, rsp_src_address  rsp_valid, one cycle
//   config    csr_index, csr_wdata                   csr_we, no wait
//
// one transaction per cycle; asw_wrap has N = ceil((42 - FRAC_BITS) / 3)
// modulo stages (9 at 16 bits)
// reset is synchronous: it empties the pipeline and restores the registers
// busy is always low, the receiver takes every response as it comes

module axis_squash_wrap_address_unit #(
   parameter int FRAC_BITS = asw_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [asw_pkg::COORD_W-1:0]        req_out_x,
   input  logic [asw_pkg::COORD_W-1:0]        req_out_y,
   output logic                               rsp_valid,
   output logic [asw_pkg::COORD_W-1:0]        rsp_src_x,
   output logic [asw_pkg::COORD_W-1:0]        rsp_src_y,
   output logic [asw_pkg::ADDR_W-1:0]         rsp_src_address,
   input  logic                               csr_we,
   input  logic [asw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [asw_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CW     = asw_pkg::COORD_W;
   localparam int DW     = asw_pkg::CFG_DIM_W;
   localparam int SW     = asw_pkg::SCALE_W;
   localparam int D_W    = CW + 1;
   localparam int PROD_W = D_W + SW;
   localparam int T_W    = PROD_W - FRAC_BITS;
   localparam int U_W    = T_W + 1;
   localparam int N_WRAP = (U_W + asw_pkg::WRAP_STEP - 1) / asw_pkg::WRAP_STEP;
   localparam int LAT    = N_WRAP + 8;
   localparam int MP_W   = 2 * DW;

   // configuration
   logic                 horizontal_ff;
   logic signed [SW-1:0] scale_ff;
   logic [DW-1:0]        width_ff;
   logic [DW-1:0]        height_ff;

   // axis selection, a is the scaled axis
   logic [DW-1:0]   dim_a;
   logic [DW-1:0]   dim_b;
   logic [DW-2:0]   half_a;
   logic [CW-1:0]   coord_a;
   logic [CW-1:0]   coord_b;
   logic            accept;

   // pipeline
   logic                     v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [D_W-1:0]    d_ff;
   logic signed [D_W-1:0]    d_in;
   logic signed [PROD_W-1:0] p_ff;
   logic signed [PROD_W-1:0] p_in;
   logic [PROD_W-1:0]        p_bias;
   logic [T_W-1:0]           t_ff;
   logic [U_W-1:0]           u_ff;
   logic [U_W-1:0]           u_in;
   logic [CW-1:0]            b1_ff, b2_ff, b3_ff, b4_ff;

   logic            wa_valid, wb_valid;
   logic [DW-1:0]   ra, rb;
   logic [DW-1:0]   sx_in, sy_in;
   logic            vm_ff;
   logic [DW-1:0]   sx_ff, sy_ff;
   logic [MP_W-1:0] mp_ff;
   logic [MP_W-1:0] addr_in;

   logic                rsp_valid_ff;
   logic [CW-1:0]       rsp_src_x_ff, rsp_src_y_ff;
   logic [asw_pkg::ADDR_W-1:0] rsp_src_address_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         horizontal_ff <= asw_pkg::RST_HORIZONTAL;
         scale_ff      <= asw_pkg::RST_SCALE;
         width_ff      <= asw_pkg::clamp_dim(asw_pkg::RST_FRAME_WIDTH);
         height_ff     <= asw_pkg::clamp_dim(asw_pkg::RST_FRAME_HEIGHT);
      end else if (csr_we) begin
         unique case (csr_index)
            asw_pkg::CSR_HORIZONTAL:   horizontal_ff <= csr_wdata[0];
            asw_pkg::CSR_SCALE:        scale_ff      <= csr_wdata[SW-1:0];
            asw_pkg::CSR_FRAME_WIDTH:  width_ff      <= asw_pkg::clamp_dim(csr_wdata[DW-1:0]);
            asw_pkg::CSR_FRAME_HEIGHT: height_ff     <= asw_pkg::clamp_dim(csr_wdata[DW-1:0]);
            default: ;
         endcase
      end
   end

   assign dim_a   = horizontal_ff ? height_ff : width_ff;
   assign dim_b   = horizontal_ff ? width_ff : height_ff;
   assign half_a  = dim_a[DW-1:1];
   assign coord_a = horizontal_ff ? req_out_y : req_out_x;
   assign coord_b = horizontal_ff ? req_out_x : req_out_y;

   // centre offset, product, truncation toward zero, half frame back
   assign d_in   = signed'({1'b0, coord_a}) - signed'({1'b0, half_a});
   assign p_in   = d_ff * scale_ff;
   assign p_bias = p_ff + (p_ff[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : PROD_W'(0));
   assign u_in   = {t_ff[T_W-1], t_ff} + U_W'(half_a);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_ff  <= d_in;
      b1_ff <= coord_b;
      p_ff  <= p_in;
      b2_ff <= b1_ff;
      t_ff  <= p_bias[PROD_W-1:FRAC_BITS];
      b3_ff <= b2_ff;
      u_ff  <= u_in;
      b4_ff <= b3_ff;
   end

   asw_wrap #(
      .VAL_W (U_W),
      .DIM_W (DW),
      .STEP  (asw_pkg::WRAP_STEP)
   ) u_wrap_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_value  (u_ff),
      .dim       (dim_a),
      .out_valid (wa_valid),
      .out_rem   (ra)
   );

   asw_wrap #(
      .VAL_W (U_W),
      .DIM_W (DW),
      .STEP  (asw_pkg::WRAP_STEP)
   ) u_wrap_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_value  (U_W'(b4_ff)),
      .dim       (dim_b),
      .out_valid (wb_valid),
      .out_rem   (rb)
   );

   assign sx_in = horizontal_ff ? rb : ra;
   assign sy_in = horizontal_ff ? ra : rb;

   // row times width, then add the column
   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else begin
         vm_ff <= wa_valid && wb_valid;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      mp_ff <= sy_in * width_ff;
   end

   assign addr_in = mp_ff + MP_W'(sx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_src_x_ff       <= sx_ff[CW-1:0];
      rsp_src_y_ff       <= sy_ff[CW-1:0];
      rsp_src_address_ff <= addr_in[asw_pkg::ADDR_W-1:0];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_src_x       = rsp_src_x_ff;
   assign rsp_src_y       = rsp_src_y_ff;
   assign rsp_src_address = rsp_src_address_ff;

   a_fwd_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(LAT) rsp_valid)
      else $error("transaction lost in pipeline");

   a_bwd_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("response without transaction");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response after reset");

endmodule
